/* hdl/debug_link_frame_parser_core_assert.svh */
// ----------------------------------------------------------------------------
// Debug-link frame parser assertion macros
// Shared property forms for the checks of the frame parser core.
// ----------------------------------------------------------------------------
`ifndef DEBUG_LINK_FRAME_PARSER_CORE_ASSERT_SVH
`define DEBUG_LINK_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define DLFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("dlfp check failed");

// Next-cycle implication, sampled on i_clk, off during reset
`define DLFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("dlfp check failed");

`endif

/* hdl/dlfp_pkg.sv */
// ----------------------------------------------------------------------------
// Debug-link frame parser package
// Word types, phase and error codes, and constants of the frame parser.
// ----------------------------------------------------------------------------
package dlfp_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 9;
    localparam int SEQ_W    = 16;
    localparam int LEN_W    = 16;
    localparam int CMP_W    = LEN_W + 1;
    localparam int HIDX_W   = 3;
    localparam int CFG_IDX_W = 1;

    // Store layout
    localparam int BUF_SIZE_DEF = 512;
    localparam logic [ADDR_W-1:0] DATA_BASE = ADDR_W'(8);

    // Header byte positions in the store
    localparam logic [HIDX_W-1:0] HDR_MARKER = 3'd0;
    localparam logic [HIDX_W-1:0] HDR_SEQ_LO = 3'd1;
    localparam logic [HIDX_W-1:0] HDR_SEQ_HI = 3'd2;
    localparam logic [HIDX_W-1:0] HDR_LEN_LO = 3'd3;
    localparam logic [HIDX_W-1:0] HDR_LEN_HI = 3'd4;
    localparam logic [HIDX_W-1:0] HDR_LAST   = 3'd6;

    // Marker reset values
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd27;
    localparam logic [BYTE_W-1:0] TOKEN_MARKER_RST = 8'd14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER = 1'b0,
        CFG_TOKEN_MARKER = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_TOKEN   = 3'd2,
        PH_DATA    = 3'd3,
        PH_FINISH  = 3'd4,
        PH_DISCARD = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_TOKEN = 2'd1,
        ERR_SIZE  = 2'd2
    } t_err;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              packet_end;
    } t_in_word;

    typedef struct packed {
        logic              store_valid;
        logic [ADDR_W-1:0] store_addr;
        logic [BYTE_W-1:0] store_byte;
        logic              frame_done;
        logic [SEQ_W-1:0]  sequence_number;
        logic [ADDR_W-1:0] payload_length;
        logic [BYTE_W-1:0] command_code;
        logic [1:0]        error_code;
    } t_out_word;

endpackage

/* hdl/dlfp_parser.sv */
// ----------------------------------------------------------------------------
// Debug-link frame parser state machine
// Holds the frame state and turns each accepted byte into one result word.
// ----------------------------------------------------------------------------
module dlfp_parser #(
    parameter int BUF_SIZE = dlfp_pkg::BUF_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  dlfp_pkg::t_in_word              i_word,
    input  logic [dlfp_pkg::BYTE_W-1:0]     i_start_marker,
    input  logic [dlfp_pkg::BYTE_W-1:0]     i_token_marker,
    output dlfp_pkg::t_out_word             o_result
);

    localparam logic [dlfp_pkg::CMP_W-1:0] BUF_LIMIT = dlfp_pkg::CMP_W'(BUF_SIZE);

    dlfp_pkg::t_phase                r_phase, n_phase;
    logic [dlfp_pkg::HIDX_W-1:0]     r_hdr_idx, n_hdr_idx;
    logic [dlfp_pkg::SEQ_W-1:0]      r_seq, n_seq;
    logic [dlfp_pkg::LEN_W-1:0]      r_rem, n_rem;
    logic [dlfp_pkg::LEN_W-1:0]      r_len, n_len;
    logic [dlfp_pkg::ADDR_W-1:0]     r_wpos, n_wpos;
    logic [dlfp_pkg::BYTE_W-1:0]     r_cmd, n_cmd;
    logic                            r_first, n_first;
    logic [dlfp_pkg::CMP_W-1:0]      frame_end;

    // State registers, advanced on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= dlfp_pkg::PH_HUNT;
            r_hdr_idx <= '0;
            r_seq     <= '0;
            r_rem     <= '0;
            r_len     <= '0;
            r_wpos    <= '0;
            r_cmd     <= '0;
            r_first   <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_seq     <= n_seq;
            r_rem     <= n_rem;
            r_len     <= n_len;
            r_wpos    <= n_wpos;
            r_cmd     <= n_cmd;
            r_first   <= n_first;
        end
    end

    // Store end of the frame: data base plus size
    assign frame_end = dlfp_pkg::CMP_W'(r_len) + dlfp_pkg::CMP_W'(dlfp_pkg::DATA_BASE);

    // Next state and result word
    always_comb begin
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_seq     = r_seq;
        n_rem     = r_rem;
        n_len     = r_len;
        n_wpos    = r_wpos;
        n_cmd     = r_cmd;
        n_first   = r_first;
        o_result  = '0;

        unique case (r_phase)
            dlfp_pkg::PH_HEADER: begin
                o_result.store_valid = 1'b1;
                o_result.store_addr  = dlfp_pkg::ADDR_W'(r_hdr_idx);
                o_result.store_byte  = i_word.data_byte;
                case (r_hdr_idx)
                    dlfp_pkg::HDR_SEQ_LO: n_seq = {8'd0, i_word.data_byte};
                    dlfp_pkg::HDR_SEQ_HI: n_seq = {i_word.data_byte, r_seq[7:0]};
                    dlfp_pkg::HDR_LEN_LO: n_len = {8'd0, i_word.data_byte};
                    dlfp_pkg::HDR_LEN_HI: n_len = {i_word.data_byte, r_len[7:0]};
                    default: ;
                endcase
                if (r_hdr_idx >= dlfp_pkg::HDR_LAST) begin
                    n_rem   = r_len;
                    n_phase = dlfp_pkg::PH_TOKEN;
                end else begin
                    n_hdr_idx = r_hdr_idx + 3'd1;
                end
            end
            dlfp_pkg::PH_TOKEN: begin
                if (i_word.data_byte != i_token_marker) begin
                    o_result.error_code = dlfp_pkg::ERR_TOKEN;
                    n_phase = dlfp_pkg::PH_HUNT;
                end else if (frame_end > BUF_LIMIT) begin
                    // frame would run past the store end: drop it
                    o_result.error_code = dlfp_pkg::ERR_SIZE;
                    n_phase = dlfp_pkg::PH_HUNT;
                end else begin
                    n_wpos  = dlfp_pkg::DATA_BASE;
                    n_cmd   = '0;
                    n_first = 1'b1;
                    n_phase = (r_rem == '0) ? dlfp_pkg::PH_FINISH : dlfp_pkg::PH_DATA;
                end
            end
            dlfp_pkg::PH_DATA: begin
                o_result.store_valid = 1'b1;
                o_result.store_addr  = r_wpos;
                o_result.store_byte  = i_word.data_byte;
                if (r_first) begin
                    n_cmd   = i_word.data_byte;
                    n_first = 1'b0;
                end
                n_wpos = r_wpos + dlfp_pkg::ADDR_W'(1);
                n_rem  = r_rem - dlfp_pkg::LEN_W'(1);
                if (n_rem == '0) begin
                    n_phase = dlfp_pkg::PH_FINISH;
                end
            end
            dlfp_pkg::PH_FINISH: begin
                o_result.frame_done      = 1'b1;
                o_result.sequence_number = r_seq;
                o_result.payload_length  = r_len[dlfp_pkg::ADDR_W-1:0];
                o_result.command_code    = r_cmd;
                n_phase = i_word.packet_end ? dlfp_pkg::PH_HUNT : dlfp_pkg::PH_DISCARD;
            end
            dlfp_pkg::PH_DISCARD: begin
                if (i_word.packet_end) begin
                    n_phase = dlfp_pkg::PH_HUNT;
                end
            end
            default: begin
                // hunting, also any unused phase code
                if (i_word.data_byte == i_start_marker) begin
                    o_result.store_valid = 1'b1;
                    o_result.store_addr  = dlfp_pkg::ADDR_W'(dlfp_pkg::HDR_MARKER);
                    o_result.store_byte  = i_word.data_byte;
                    n_hdr_idx = dlfp_pkg::HDR_SEQ_LO;
                    n_seq     = '0;
                    n_len     = '0;
                    n_phase   = dlfp_pkg::PH_HEADER;
                end else begin
                    n_phase = dlfp_pkg::PH_HUNT;
                end
            end
        endcase
    end

endmodule

/* hdl/debug_link_frame_parser_core.sv */
// ----------------------------------------------------------------------------
// Debug-link frame parser core
// Parses length-prefixed frames from USB bulk bytes into message store writes.
// ----------------------------------------------------------------------------
// The core takes one byte word per clock while o_in_stall is low and gives
// exactly one result word per byte: a store write, a frame completion, an
// error, or an empty word. Each result is registered in the output register,
// or in the one skid entry while the output stalls, so a stalled result does
// not stop the input: o_in_stall rises only once both are full, and sustained
// throughput is one byte per cycle while the output drains. Marker registers
// may be written through the configuration port at any time the core is idle;
// o_cfg_ready is always high.
`include "debug_link_frame_parser_core_assert.svh"

module debug_link_frame_parser_core #(
    parameter int BUF_SIZE = dlfp_pkg::BUF_SIZE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input byte channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  dlfp_pkg::t_in_word                 i_in_word,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output dlfp_pkg::t_out_word                o_out_word,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dlfp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dlfp_pkg::BYTE_W-1:0]        i_cfg_data
);

    logic [dlfp_pkg::BYTE_W-1:0] r_start_marker;
    logic [dlfp_pkg::BYTE_W-1:0] r_token_marker;
    logic                        r_out_valid;
    dlfp_pkg::t_out_word         r_out_word;
    logic                        r_skid_valid;
    dlfp_pkg::t_out_word         r_skid_word;
    dlfp_pkg::t_out_word         step_result;
    logic                        in_accept;
    logic                        out_free;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= dlfp_pkg::START_MARKER_RST;
            r_token_marker <= dlfp_pkg::TOKEN_MARKER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (dlfp_pkg::t_cfg_idx'(i_cfg_index))
                dlfp_pkg::CFG_START_MARKER: r_start_marker <= i_cfg_data;
                dlfp_pkg::CFG_TOKEN_MARKER: r_token_marker <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input handshake
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    dlfp_parser #(
        .BUF_SIZE (BUF_SIZE)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_word         (i_in_word),
        .i_start_marker (r_start_marker),
        .i_token_marker (r_token_marker),
        .o_result       (step_result)
    );

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_word <= r_skid_valid ? r_skid_word : step_result;
        end
        if (!out_free && in_accept) begin
            r_skid_word <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Checks
    `DLFP_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    `DLFP_ASSERT_NOW(a_done_not_store, o_out_valid,
        !(o_out_word.frame_done && o_out_word.store_valid))
    `DLFP_ASSERT_NOW(a_error_is_silent,
        o_out_valid && (o_out_word.error_code != dlfp_pkg::ERR_NONE),
        !o_out_word.store_valid && !o_out_word.frame_done)
    `DLFP_ASSERT_NEXT(a_skid_kept, r_skid_valid && i_out_stall, r_skid_valid)

endmodule

/* bench/debug_link_frame_parser_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Debug-link frame parser core testbench
// Streams USB bulk bytes through the parser, predicts every result word with
// an in-bench parser model, and compares each accepted word field by field.
// Both channels idle at random. The markers are changed between traffic
// phases, only once the core has drained.
// ----------------------------------------------------------------------------
module debug_link_frame_parser_core_tb;

    localparam int BUF_BYTES   = dlfp_pkg::BUF_SIZE_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                                i_in_valid  = 1'b0;
    logic                                o_in_stall;
    dlfp_pkg::t_in_word                  i_in_word   = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    dlfp_pkg::t_out_word                 o_out_word;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [dlfp_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [dlfp_pkg::BYTE_W-1:0]         i_cfg_data  = '0;

    debug_link_frame_parser_core #(
        .BUF_SIZE(BUF_BYTES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Byte words waiting to be sent, result words waiting to arrive
    dlfp_pkg::t_in_word  usb_bytes[$];
    dlfp_pkg::t_out_word parsed_words[$];
    int                  bytes_queued = 0;

    // Parser model state and marker copies
    logic [dlfp_pkg::BYTE_W-1:0] start_mk  = dlfp_pkg::START_MARKER_RST;
    logic [dlfp_pkg::BYTE_W-1:0] token_mk  = dlfp_pkg::TOKEN_MARKER_RST;
    dlfp_pkg::t_phase            ph        = dlfp_pkg::PH_HUNT;
    logic [2:0]                  hdr_idx   = '0;
    logic [15:0]                 seq_hold  = '0;
    logic [15:0]                 remaining = '0;
    logic [15:0]                 len_hold  = '0;
    logic [16:0]                 wr_pos    = '0;
    logic [7:0]                  cmd_hold  = '0;

    // Handshake bookkeeping
    logic                in_taken    = 1'b0;
    logic                out_taken   = 1'b0;
    int                  in_gap      = 0;
    int                  in_burst    = 0;
    int                  out_wait    = 0;
    int                  out_burst   = 0;
    int                  fault_count = 0;
    int                  cycle_count = 0;
    dlfp_pkg::t_out_word head_word;
    logic [7:0]          shared_mk;

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Parser model: one byte word in, one result word out
    task automatic parse_byte(input dlfp_pkg::t_in_word w);
        dlfp_pkg::t_out_word r;
        r = '0;
        case (ph)
            dlfp_pkg::PH_HEADER: begin
                r.store_valid = 1'b1;
                r.store_addr  = dlfp_pkg::ADDR_W'(hdr_idx);
                r.store_byte  = w.data_byte;
                case (hdr_idx)
                    dlfp_pkg::HDR_SEQ_LO: seq_hold = {8'd0, w.data_byte};
                    dlfp_pkg::HDR_SEQ_HI: seq_hold[15:8] = w.data_byte;
                    dlfp_pkg::HDR_LEN_LO: len_hold = {8'd0, w.data_byte};
                    dlfp_pkg::HDR_LEN_HI: len_hold[15:8] = w.data_byte;
                    default: ;
                endcase
                if (hdr_idx >= dlfp_pkg::HDR_LAST) begin
                    remaining = len_hold;
                    ph = dlfp_pkg::PH_TOKEN;
                end else begin
                    hdr_idx = hdr_idx + 3'd1;
                end
            end
            dlfp_pkg::PH_TOKEN: begin
                if (w.data_byte != token_mk) begin
                    r.error_code = dlfp_pkg::ERR_TOKEN;
                    ph = dlfp_pkg::PH_HUNT;
                end else if (int'(dlfp_pkg::DATA_BASE) + int'(len_hold) > BUF_BYTES) begin
                    // frame would overflow the store: dropped
                    r.error_code = dlfp_pkg::ERR_SIZE;
                    ph = dlfp_pkg::PH_HUNT;
                end else begin
                    wr_pos   = 17'(dlfp_pkg::DATA_BASE);
                    cmd_hold = '0;
                    ph = (remaining == 16'd0) ? dlfp_pkg::PH_FINISH : dlfp_pkg::PH_DATA;
                end
            end
            dlfp_pkg::PH_DATA: begin
                r.store_valid = 1'b1;
                r.store_addr  = wr_pos[dlfp_pkg::ADDR_W-1:0];
                r.store_byte  = w.data_byte;
                if (wr_pos == 17'(dlfp_pkg::DATA_BASE))
                    cmd_hold = w.data_byte;
                wr_pos    = wr_pos + 17'd1;
                remaining = remaining - 16'd1;
                if (remaining == 16'd0)
                    ph = dlfp_pkg::PH_FINISH;
            end
            dlfp_pkg::PH_FINISH: begin
                r.frame_done      = 1'b1;
                r.sequence_number = seq_hold;
                r.payload_length  = len_hold[dlfp_pkg::ADDR_W-1:0];
                r.command_code    = cmd_hold;
                ph = w.packet_end ? dlfp_pkg::PH_HUNT : dlfp_pkg::PH_DISCARD;
            end
            dlfp_pkg::PH_DISCARD: begin
                if (w.packet_end)
                    ph = dlfp_pkg::PH_HUNT;
            end
            default: begin
                if (w.data_byte == start_mk) begin
                    r.store_valid = 1'b1;
                    r.store_addr  = dlfp_pkg::ADDR_W'(dlfp_pkg::HDR_MARKER);
                    r.store_byte  = w.data_byte;
                    hdr_idx  = dlfp_pkg::HDR_SEQ_LO;
                    seq_hold = '0;
                    len_hold = '0;
                    ph = dlfp_pkg::PH_HEADER;
                end else begin
                    ph = dlfp_pkg::PH_HUNT;
                end
            end
        endcase
        parsed_words.push_back(r);
    endtask

    function automatic string word_text(input dlfp_pkg::t_out_word w);
        return $sformatf("sv=%0d addr=%0d byte=%02h done=%0d seq=%04h len=%0d cmd=%02h err=%0d",
                         w.store_valid, w.store_addr, w.store_byte, w.frame_done,
                         w.sequence_number, w.payload_length, w.command_code,
                         w.error_code);
    endfunction

    // Stimulus building
    function automatic logic rnd_end();
        return ($urandom_range(0, 7) == 0);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        dlfp_pkg::t_in_word w;
        w.data_byte  = b;
        w.packet_end = last;
        usb_bytes.push_back(w);
        bytes_queued++;
    endtask

    // Marker, header, token; data, closing byte, packet tail if good and fitting
    task automatic push_frame(input logic [15:0] seq, input logic [15:0] size,
                              input logic [15:0] size_top, input bit bad_token,
                              input int tail);
        int i;
        logic [7:0] tok;
        push_byte(start_mk, rnd_end());
        push_byte(seq[7:0], rnd_end());
        push_byte(seq[15:8], rnd_end());
        push_byte(size[7:0], rnd_end());
        push_byte(size[15:8], rnd_end());
        push_byte(size_top[7:0], rnd_end());
        push_byte(size_top[15:8], rnd_end());
        tok = bad_token ? (token_mk ^ 8'($urandom_range(1, 255))) : token_mk;
        push_byte(tok, rnd_end());
        if (!bad_token && int'(size) + int'(dlfp_pkg::DATA_BASE) <= BUF_BYTES) begin
            for (i = 0; i < int'(size); i++)
                push_byte(8'($urandom_range(0, 255)), rnd_end());
            push_byte(8'($urandom_range(0, 255)), tail == 0);
            for (i = 1; i <= tail; i++)
                push_byte(8'($urandom_range(0, 255)), i == tail);
        end
    endtask

    // Mostly good frames with small payloads, plus errors, cut frames, noise
    task automatic push_random_traffic(input int n_bytes);
        int base_count;
        int pick;
        int cnt;
        base_count = bytes_queued;
        while (bytes_queued - base_count < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                push_frame(16'($urandom), 16'($urandom_range(0, 24)),
                           ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000,
                           1'b0, $urandom_range(0, 3));
            end else if (pick < 81) begin
                push_frame(16'($urandom), 16'($urandom_range(0, 24)), 16'h0000,
                           1'b1, 0);
            end else if (pick < 87) begin
                push_frame(16'($urandom), 16'($urandom_range(505, 65535)),
                           16'($urandom), 1'b0, 0);
            end else if (pick < 93) begin
                // frame cut short inside its header
                push_byte(start_mk, rnd_end());
                cnt = $urandom_range(1, 5);
                repeat (cnt) push_byte(8'($urandom_range(0, 255)), rnd_end());
            end else begin
                cnt = $urandom_range(1, 5);
                repeat (cnt) push_byte(8'($urandom_range(0, 255)), rnd_end());
            end
        end
    endtask

    // Wait until every sent byte has produced its result word
    task automatic settle_idle();
        while (usb_bytes.size() != 0 || i_in_valid || parsed_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input dlfp_pkg::t_cfg_idx idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == dlfp_pkg::CFG_START_MARKER)
            start_mk = value;
        else
            token_mk = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Byte driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (usb_bytes.size() != 0) begin
                i_in_word  <= usb_bytes.pop_front();
                i_in_valid <= 1'b1;
                if (in_burst > 0) begin
                    in_burst = in_burst - 1;
                    in_gap = 0;
                end else if ($urandom_range(0, 15) == 0) begin
                    in_burst = $urandom_range(10, 40);
                    in_gap = 0;
                end else begin
                    in_gap = $urandom_range(0, 14);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result stall driver: a fresh wait after every taken word
    always @(negedge i_clk) begin
        if (out_taken) begin
            if (out_burst > 0) begin
                out_burst = out_burst - 1;
                out_wait = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                out_burst = $urandom_range(10, 40);
                out_wait = 0;
            end else begin
                out_wait = $urandom_range(0, 14);
            end
        end
        if (out_wait > 0) begin
            out_wait = out_wait - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Predict on every accepted byte word
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        if (i_rst_n && i_in_valid && o_in_stall === 1'b0)
            parse_byte(i_in_word);
    end

    // Compare every accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        out_taken <= i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (parsed_words.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected result word: %s", word_text(o_out_word));
            end else begin
                head_word = parsed_words.pop_front();
                if (o_out_word.store_valid     !== head_word.store_valid     ||
                    o_out_word.store_addr      !== head_word.store_addr      ||
                    o_out_word.store_byte      !== head_word.store_byte      ||
                    o_out_word.frame_done      !== head_word.frame_done      ||
                    o_out_word.sequence_number !== head_word.sequence_number ||
                    o_out_word.payload_length  !== head_word.payload_length  ||
                    o_out_word.command_code    !== head_word.command_code    ||
                    o_out_word.error_code      !== head_word.error_code) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("mismatch: exp %s | got %s",
                                 word_text(head_word), word_text(o_out_word));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Reset, then the traffic phases
    initial begin
        // directed: noise, empty frame, token mismatch, oversize frame
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_frame(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1);
        push_frame(16'h0000, 16'h0003, 16'h0000, 1'b1, 0);
        push_frame(16'h1234, 16'hFFFF, 16'hFFFF, 1'b0, 0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settle_idle();

        cfg_write(dlfp_pkg::CFG_START_MARKER, 8'h00);
        cfg_write(dlfp_pkg::CFG_TOKEN_MARKER, 8'hFF);
        push_random_traffic(85);
        settle_idle();

        cfg_write(dlfp_pkg::CFG_START_MARKER, 8'hFF);
        cfg_write(dlfp_pkg::CFG_TOKEN_MARKER, 8'h00);
        push_random_traffic(85);
        settle_idle();

        // random markers, then the first size that no longer fits
        cfg_write(dlfp_pkg::CFG_START_MARKER, 8'($urandom_range(0, 255)));
        cfg_write(dlfp_pkg::CFG_TOKEN_MARKER, 8'($urandom_range(0, 255)));
        push_random_traffic(85);
        push_frame(16'($urandom), 16'(BUF_BYTES - int'(dlfp_pkg::DATA_BASE) + 1),
                   16'h0000, 1'b0, 0);
        settle_idle();

        // start and token marker equal
        shared_mk = 8'($urandom_range(0, 255));
        cfg_write(dlfp_pkg::CFG_START_MARKER, shared_mk);
        cfg_write(dlfp_pkg::CFG_TOKEN_MARKER, shared_mk);
        push_random_traffic(85);
        settle_idle();

        repeat (8) @(posedge i_clk);
        if (fault_count == 0 && parsed_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* debug_link_frame_parser_core.f */
+incdir+hdl
hdl/dlfp_pkg.sv
hdl/dlfp_parser.sv
hdl/debug_link_frame_parser_core.sv
bench/debug_link_frame_parser_core_tb.sv
